// File: rtl/sync_length_frame_crc_checker_macros.svh
// Assertion macros for the sync/length framed CRC checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SYNC_LENGTH_FRAME_CRC_CHECKER_MACROS_SVH
`define SYNC_LENGTH_FRAME_CRC_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLFCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/slfcc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed CRC checker.
// No dependencies; used by slfcc_hunt and sync_length_frame_crc_checker.
package slfcc_pkg;

    localparam logic [15:0] CCITT_GENERATOR = 16'h1021;
    localparam logic [7:0]  SYNC_FIRST      = 8'h55;
    localparam logic [7:0]  SYNC_SECOND     = 8'hAA;
    localparam logic [7:0]  KIND_RESET      = 8'h36;
    localparam logic [15:0] FIXED_RESET     = 16'h0000;
    localparam logic [15:0] FIXED_MIN       = 16'd7;
    localparam logic [16:0] HEADER_EXTRA    = 17'd6;
    localparam logic [16:0] SHORT_TOTAL     = 17'd6;
    localparam logic [16:0] MATCH_OFFSET    = 17'd5;
    localparam logic [2:0]  WINDOW_FULL     = 3'd4;

    localparam int          ADDR_W          = 3;
    localparam int          DATA_W          = 32;

    // Register index, taken from the word address.
    typedef enum logic [0:0] {
        REG_FRAME_KIND   = 1'b0,
        REG_FIXED_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_ZERO_LEN  = 2'd2
    } frame_status_t;

    // What the hunt window reports for the byte on the input.
    typedef struct packed {
        logic        match;
        logic [15:0] length_field;
        logic [15:0] window_crc;
    } hunt_info_t;

    // CRC-16 (poly 0x1021, MSB first) over one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_GENERATOR) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/slfcc_hunt.sv
// Sync hunt window: last four bytes, fill count and a running CRC of the length bytes.
// Depends on slfcc_pkg.
module slfcc_hunt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  drop,
    input  logic [7:0]            in_byte,
    input  logic [7:0]            frame_kind,
    output slfcc_pkg::hunt_info_t info
);

    logic [7:0]  win0_reg, win1_reg, win2_reg, win3_reg;
    logic [2:0]  fill_reg, fill_next;
    logic [15:0] last_crc_reg;
    logic [15:0] pair_crc_reg;
    logic        match;
    logic        shift;

    assign match = (fill_reg == slfcc_pkg::WINDOW_FULL)
                && (win0_reg == slfcc_pkg::SYNC_FIRST)
                && (win1_reg == slfcc_pkg::SYNC_SECOND)
                && (in_byte == frame_kind);

    assign shift = en && !match && !drop;

    assign info.match        = match;
    assign info.length_field = {win3_reg, win2_reg};
    assign info.window_crc   = pair_crc_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (drop || (en && match))
        begin
            fill_next = 3'd0;
        end
        else if (shift && (fill_reg != slfcc_pkg::WINDOW_FULL))
        begin
            fill_next = fill_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Window bytes are not read until four shifts have refilled them.
    // pair_crc tracks CRC(0, byte two, byte three) once two shifts are in.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win0_reg     <= win1_reg;
            win1_reg     <= win2_reg;
            win2_reg     <= win3_reg;
            win3_reg     <= in_byte;
            last_crc_reg <= slfcc_pkg::crc16_byte(16'h0000, in_byte);
            pair_crc_reg <= slfcc_pkg::crc16_byte(last_crc_reg, in_byte);
        end
    end

endmodule

// File: rtl/sync_length_frame_crc_checker.sv
// Top level of the sync/length framed CRC-16 checker.
// Depends on slfcc_pkg, slfcc_hunt and sync_length_frame_crc_checker_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries the raw stream, one byte
//   per request. The block hunts for 0x55 0xAA, two length bytes and the kind
//   byte, then follows the frame to its end; the length comes from the field
//   plus six, or from fixed_length when that register holds 7 or more.
//   Output channel (out_valid/out_ready) carries one request per frame: status,
//   frame_bytes, computed and received CRC and the frame number.
//   Throughput: one byte per cycle unless stalled; each byte passes through
//   one CRC-16 byte update between the input port and the state registers.
//   Latency: the result is registered and shows on out_valid the cycle after
//   the last frame byte is accepted.
//   Stall: while a result waits, bytes that do not end a frame are still
//   taken; in_ready drops only for a frame's last byte until the result leaves.
//   Reset: hunting, empty window, frame count zero, frame_kind 0x36,
//   fixed_length 0. Write the registers over the APB port while idle.
`include "sync_length_frame_crc_checker_macros.svh"

module sync_length_frame_crc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    // byte input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    // frame result
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [16:0]                      frame_bytes,
    output logic [15:0]                      computed_crc,
    output logic [15:0]                      received_crc,
    output logic [15:0]                      frame_number,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slfcc_pkg::ADDR_W-1:0]     paddr,
    input  logic [slfcc_pkg::DATA_W-1:0]     pwdata,
    output logic [slfcc_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    slfcc_pkg::hunt_info_t hunt;
    slfcc_pkg::reg_index_t reg_sel;

    logic [7:0]  kind_reg;
    logic [15:0] fixed_reg;

    logic        active_reg, active_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;

    logic [16:0] total_reg;
    logic        short_reg;
    logic [15:0] crc_reg;
    logic [7:0]  trailer_reg;

    logic [1:0]  status_reg;
    logic [16:0] bytes_reg;
    logic [15:0] comp_reg, recv_reg, number_reg;

    logic        in_fire, emit_now, hunt_en, match_fire, cfg_write;
    logic [16:0] match_total;
    logic        match_short;
    logic [15:0] rx_crc;
    logic [15:0] byte_crc;

    assign pready    = 1'b1;
    assign reg_sel   = slfcc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            slfcc_pkg::REG_FRAME_KIND:   prdata = {24'd0, kind_reg};
            slfcc_pkg::REG_FIXED_LENGTH: prdata = {16'd0, fixed_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= slfcc_pkg::KIND_RESET;
            fixed_reg <= slfcc_pkg::FIXED_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                slfcc_pkg::REG_FRAME_KIND:   kind_reg  <= pwdata[7:0];
                slfcc_pkg::REG_FIXED_LENGTH: fixed_reg <= pwdata[15:0];
                default:                     kind_reg  <= kind_reg;
            endcase
        end
    end

    // Only a frame's last byte produces a result, and that is known from state.
    assign emit_now   = active_reg && (rem_reg == 17'd1);
    assign in_ready   = !(emit_now && out_valid_reg && !out_ready);
    assign in_fire    = in_valid && in_ready;
    assign hunt_en    = in_fire && !active_reg;
    assign match_fire = hunt_en && hunt.match;

    slfcc_hunt u_hunt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (hunt_en),
        .drop       (in_fire && emit_now),
        .in_byte    (in_byte),
        .frame_kind (kind_reg),
        .info       (hunt)
    );

    assign match_total = (fixed_reg >= slfcc_pkg::FIXED_MIN)
                       ? {1'b0, fixed_reg}
                       : ({1'b0, hunt.length_field} + slfcc_pkg::HEADER_EXTRA);
    assign match_short = (match_total == slfcc_pkg::SHORT_TOTAL);
    assign byte_crc    = slfcc_pkg::crc16_byte(active_reg ? crc_reg : hunt.window_crc,
                                               in_byte);
    assign rx_crc      = {in_byte, trailer_reg};

    always_comb
    begin
        active_next    = active_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (match_fire)
        begin
            active_next = 1'b1;
            rem_next    = match_total - slfcc_pkg::MATCH_OFFSET;
            count_next  = count_reg + 16'd1;
        end
        else if (in_fire && emit_now)
        begin
            active_next    = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (in_fire && active_reg)
        begin
            rem_next = rem_reg - 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rem_reg       <= 17'd0;
            count_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rem_reg       <= rem_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame payload state; written at the match before any read.
    always_ff @(posedge clk)
    begin
        if (match_fire)
        begin
            total_reg   <= match_total;
            short_reg   <= match_short;
            crc_reg     <= match_short ? hunt.window_crc : byte_crc;
            trailer_reg <= match_short ? in_byte : 8'h00;
        end
        else if (in_fire && active_reg && !emit_now)
        begin
            if (rem_reg > 17'd2)
            begin
                crc_reg <= byte_crc;
            end
            else
            begin
                trailer_reg <= in_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit_now)
        begin
            if (short_reg)
            begin
                status_reg <= slfcc_pkg::ST_ZERO_LEN;
            end
            else if (rx_crc == crc_reg)
            begin
                status_reg <= slfcc_pkg::ST_GOOD;
            end
            else
            begin
                status_reg <= slfcc_pkg::ST_MISMATCH;
            end
            bytes_reg  <= total_reg;
            comp_reg   <= crc_reg;
            recv_reg   <= rx_crc;
            number_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_bytes  = bytes_reg;
    assign computed_crc = comp_reg;
    assign received_crc = recv_reg;
    assign frame_number = number_reg;

    `SLFCC_ASSERT_NOW(a_rem_nonzero, clk, rst_n, active_reg, rem_reg != 17'd0, "frame active with no bytes left")
    `SLFCC_ASSERT_NOW(a_total_min, clk, rst_n, active_reg, total_reg >= slfcc_pkg::SHORT_TOTAL, "frame shorter than six bytes")
    `SLFCC_ASSERT_NEXT(a_end_result, clk, rst_n, in_fire && emit_now, out_valid_reg && !active_reg, "frame end without result or back to hunt")

endmodule
